>>> hw/rtl/tpmf_pkg.sv
package tpmf_pkg;

	localparam logic [7:0] SEP_CHAR = 8'd32;
	localparam logic [7:0] EOL_CHAR = 8'd10;
	localparam logic [15:0] LINE_MAX = 16'hFFFF;

	localparam int ROW_W = 16;
	localparam int COL_W = 13;
	localparam int CNT_W = 4;
	localparam int PLEN_W = 4;
	localparam int PAT_W = 64;

	localparam logic [1:0] REG_PATTERN_WORD = 2'd0;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
	localparam logic [1:0] REG_MATCH_THRESHOLD = 2'd2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic [CNT_W-1:0] match_count;
	} tpmf_rec_t;

endpackage

>>> hw/rtl/token_position_match_finder_top.sv
// Channel      | Dir | Handshake                      | Payload
// s_axis       | in  | s_axis_tvalid / s_axis_tready  | tdata: text_byte; tuser: mode
// m_axis       | out | m_axis_tvalid / m_axis_tready  | tdata: row, column, match_count
// cfg          | in  | cfg_we                         | cfg_index, cfg_data
//
// One word accepted per cycle; the word that closes a token writes its record into the
// queue at its accepting edge; the report loads into the output register when free.
// A four-entry record queue between front and back lets input keep flowing while
// the output is stalled; input stalls only once that queue fills.
// Reset (arst_n low) sets row 1, column offset 0, empty token, zero config, empty queue.
module token_position_match_finder_top import tpmf_pkg::*; #(
	parameter int MAX_PATTERN_CHARS = 8,
	parameter int COLUMN_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
	input  logic        s_axis_tuser,  // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [15:0] row, [28:16] column, [32:29] match_count
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [PAT_W-1:0]  pattern_word_q;
	logic [PLEN_W-1:0] pattern_length_q;
	logic [CNT_W-1:0]  match_threshold_q;

	logic      q_full;
	logic      push;
	tpmf_rec_t push_rec;
	logic      pop;
	logic      head_valid;
	tpmf_rec_t head_rec;
	tpmf_rec_t out_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_word_q    <= '0;
			pattern_length_q  <= '0;
			match_threshold_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_WORD:    pattern_word_q    <= cfg_data;
				REG_PATTERN_LENGTH:  pattern_length_q  <= cfg_data[PLEN_W-1:0];
				REG_MATCH_THRESHOLD: match_threshold_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	tpmf_front #(
		.MAX_PATTERN_CHARS(MAX_PATTERN_CHARS),
		.COLUMN_BITS(COLUMN_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_mode(s_axis_tuser),
		.in_byte(s_axis_tdata),
		.pattern_word(pattern_word_q),
		.pattern_length(pattern_length_q),
		.q_full(q_full),
		.push(push),
		.push_rec(push_rec)
	);

	tpmf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_rec(push_rec),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_rec(head_rec)
	);

	tpmf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_rec(head_rec),
		.pop(pop),
		.match_threshold(match_threshold_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_rec(out_rec)
	);

	assign m_axis_tdata = {7'd0, out_rec.match_count, out_rec.column, out_rec.row};

endmodule

>>> hw/rtl/tpmf_front.sv
module tpmf_front import tpmf_pkg::*; #(
	parameter int MAX_PATTERN_CHARS = 8,
	parameter int COLUMN_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_mode,
	input  logic [7:0]        in_byte,
	input  logic [PAT_W-1:0]  pattern_word,
	input  logic [PLEN_W-1:0] pattern_length,
	input  logic              q_full,
	output logic              push,
	output tpmf_rec_t         push_rec
);

	localparam int AW = COLUMN_BITS + 2;
	localparam logic [COLUMN_BITS-1:0] OFF_MAX = '1;

	logic [ROW_W-1:0]       line_q;
	logic [COLUMN_BITS-1:0] off_q;
	logic [COLUMN_BITS-1:0] len_q;
	logic [CNT_W-1:0]       eq_q;

	logic                   accept;
	logic                   is_sep;
	logic                   is_eol;
	logic                   nonempty;
	logic                   do_close;
	logic [PLEN_W-1:0]      plen;
	logic [2:0]             idx;
	logic                   in_pat;
	logic                   chr_hit;
	logic [AW-1:0]          adv;
	logic [COLUMN_BITS-1:0] adv_sat;
	logic [COLUMN_BITS-1:0] len_inc;
	logic [16:0]            col_full;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	assign is_sep   = !in_mode && (in_byte == SEP_CHAR);
	assign is_eol   = !in_mode && (in_byte == EOL_CHAR);
	assign nonempty = (len_q != '0);
	assign do_close = is_sep || ((is_eol || in_mode) && nonempty);

	assign plen   = (pattern_length > PLEN_W'(MAX_PATTERN_CHARS)) ?
	                PLEN_W'(MAX_PATTERN_CHARS) : pattern_length;
	assign idx    = len_q[2:0];
	assign in_pat = (len_q < COLUMN_BITS'(plen));
	assign chr_hit = in_pat && (pattern_word[{idx, 3'b000} +: 8] == in_byte);

	assign adv     = AW'(off_q) + AW'(len_q) + AW'(1);
	assign adv_sat = (adv > AW'(OFF_MAX)) ? OFF_MAX : adv[COLUMN_BITS-1:0];
	assign len_inc = (len_q == OFF_MAX) ? len_q : len_q + COLUMN_BITS'(1);

	assign col_full = 17'(off_q) + 17'd1;

	assign push = accept && do_close;
	always_comb begin
		push_rec.row         = line_q;
		push_rec.column      = col_full[COL_W-1:0];
		push_rec.match_count = eq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= ROW_W'(1);
			off_q  <= '0;
			len_q  <= '0;
			eq_q   <= '0;
		end else if (accept) begin
			if (in_mode) begin
				line_q <= ROW_W'(1);
				off_q  <= '0;
				len_q  <= '0;
				eq_q   <= '0;
			end else if (is_sep) begin
				off_q <= adv_sat;
				len_q <= '0;
				eq_q  <= '0;
			end else if (is_eol) begin
				if (line_q != LINE_MAX) begin
					line_q <= line_q + ROW_W'(1);
				end
				off_q <= '0;
				len_q <= '0;
				eq_q  <= '0;
			end else begin
				if (chr_hit) begin
					eq_q <= eq_q + CNT_W'(1);
				end
				len_q <= len_inc;
			end
		end
	end

endmodule

>>> hw/rtl/tpmf_queue.sv
module tpmf_queue import tpmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tpmf_rec_t push_rec,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output tpmf_rec_t head_rec
);

	tpmf_rec_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - QCNT_W'(1)))
		else $error("queue count did not drop on read");

endmodule

>>> hw/rtl/tpmf_back.sv
module tpmf_back import tpmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  tpmf_rec_t        head_rec,
	output logic             pop,
	input  logic [CNT_W-1:0] match_threshold,
	output logic             out_valid,
	input  logic             out_ready,
	output tpmf_rec_t        out_rec
);

	logic      out_valid_q;
	tpmf_rec_t out_rec_q;
	logic      hit;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign hit       = (head_rec.match_count >= match_threshold);
	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && hit) begin
			out_rec_q <= head_rec;
		end
	end

	a_out_meets_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_rec_q.match_count >= match_threshold))
		else $error("reported word below threshold");

	a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !pop)
		else $error("record dropped while output stalled");

	a_load_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && hit) |=> out_valid_q)
		else $error("hit record not presented");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tpmf_pkg::*;

	localparam int OFFSET_MAX = 4095;
	localparam int PATTERN_CHARS = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PHASES = 6;
	localparam logic MODE_TEXT = 1'b0;
	localparam logic MODE_END = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] text_byte;
	} text_word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] text_byte
	logic        s_axis_tuser = 1'b0; // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // [15:0] row, [28:16] column, [32:29] match_count
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	text_word_t text_q[$];
	text_word_t cur_word;
	tpmf_rec_t  report_q[$];
	tpmf_rec_t  want_rec;
	int         words_in_flight = 0;
	int         send_gap = 0;
	int         recv_stall = 0;
	bit         send_idle_on = 1'b1;
	bit         recv_idle_on = 1'b1;
	int         idle_cycles = 0;
	int         fail_count = 0;

	logic [63:0] pat_word = '0;
	logic [3:0]  pat_len = '0;
	logic [3:0]  hit_floor = '0;

	logic [15:0] line_no = 16'd1;
	int          tok_off = 0;
	int          tok_len = 0;
	int          tok_hits = 0;

	token_position_match_finder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void close_token();
		tpmf_rec_t rec;
		if (tok_hits >= hit_floor) begin
			rec.row = line_no;
			rec.column = COL_W'(tok_off + 1);
			rec.match_count = CNT_W'(tok_hits);
			report_q.push_back(rec);
		end
		tok_off = (tok_off + tok_len + 1 > OFFSET_MAX) ? OFFSET_MAX : tok_off + tok_len + 1;
		tok_len = 0;
		tok_hits = 0;
	endfunction

	function automatic void scan_word(input text_word_t w);
		int plen;
		plen = (pat_len > PATTERN_CHARS) ? PATTERN_CHARS : int'(pat_len);
		if (w.mode == MODE_END) begin
			if (tok_len > 0)
				close_token();
			line_no = 16'd1;
			tok_off = 0;
			tok_len = 0;
			tok_hits = 0;
		end else if (w.text_byte == SEP_CHAR) begin
			close_token();
		end else if (w.text_byte == EOL_CHAR) begin
			if (tok_len > 0)
				close_token();
			if (line_no != LINE_MAX)
				line_no = line_no + 16'd1;
			tok_off = 0;
			tok_len = 0;
			tok_hits = 0;
		end else begin
			if (tok_len < plen) begin
				if (pat_word[8*tok_len +: 8] == w.text_byte)
					tok_hits++;
			end
			if (tok_len < OFFSET_MAX)
				tok_len++;
		end
	endfunction

	function automatic void push_word(input logic mode, input logic [7:0] b);
		text_word_t w;
		w.mode = mode;
		w.text_byte = b;
		text_q.push_back(w);
		words_in_flight++;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_word(MODE_TEXT, s[i]);
	endfunction

	function automatic logic [7:0] rand_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == SEP_CHAR || b == EOL_CHAR);
		return b;
	endfunction

	// mostly tokens built on the pattern with a few altered characters, plus raw noise
	function automatic void push_random_text(input int n);
		int made;
		int len;
		int r;
		logic [7:0] c;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 9);
				for (int i = 0; i < len; i++) begin
					if (i < PATTERN_CHARS)
						c = pat_word[8*i +: 8];
					else
						c = rand_char();
					if (c == SEP_CHAR || c == EOL_CHAR || $urandom_range(0, 7) == 0)
						c = rand_char();
					push_word(MODE_TEXT, c);
				end
				r = $urandom_range(0, 99);
				if (r < 75)
					push_word(MODE_TEXT, SEP_CHAR);
				else if (r < 95)
					push_word(MODE_TEXT, EOL_CHAR);
				else
					push_word(MODE_END, 8'($urandom_range(0, 255)));
				made += len + 1;
			end else if (r < 88) begin
				push_word(MODE_TEXT, 8'($urandom_range(0, 255)));
				made++;
			end else if (r < 96) begin
				push_word(MODE_TEXT, ($urandom_range(0, 1) == 1) ? SEP_CHAR : EOL_CHAR);
				made++;
			end else begin
				push_word(MODE_END, 8'($urandom_range(0, 255)));
				made++;
			end
		end
	endfunction

	task automatic drain_reports();
		while (words_in_flight != 0 || report_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PATTERN_WORD: pat_word = value;
			REG_PATTERN_LENGTH: pat_len = value[3:0];
			REG_MATCH_THRESHOLD: hit_floor = value[3:0];
			default: ;
		endcase
	endtask

	task automatic load_pattern(input logic [63:0] word, input int len, input int floor_val);
		write_reg(REG_PATTERN_WORD, word);
		write_reg(REG_PATTERN_LENGTH, 64'(len));
		write_reg(REG_MATCH_THRESHOLD, 64'(floor_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				scan_word(cur_word);
				words_in_flight--;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (text_q.size() > 0) begin
					cur_word = text_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= cur_word.text_byte;
					s_axis_tuser <= cur_word.mode;
					send_gap = send_idle_on ? $urandom_range(0, 16) : 0;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (report_q.size() == 0) begin
					$error("report word with none expected: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want_rec = report_q.pop_front();
					if (m_axis_tdata[ROW_W-1:0] !== want_rec.row) begin
						$error("row: expected %0d, got %0d", want_rec.row,
							m_axis_tdata[ROW_W-1:0]);
						fail_count++;
					end
					if (m_axis_tdata[ROW_W +: COL_W] !== want_rec.column) begin
						$error("column: expected %0d, got %0d", want_rec.column,
							m_axis_tdata[ROW_W +: COL_W]);
						fail_count++;
					end
					if (m_axis_tdata[ROW_W+COL_W +: CNT_W] !== want_rec.match_count) begin
						$error("match_count: expected %0d, got %0d", want_rec.match_count,
							m_axis_tdata[ROW_W+COL_W +: CNT_W]);
						fail_count++;
					end
				end
				recv_stall = recv_idle_on ? $urandom_range(0, 16) : 0;
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		int plen_pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: every closed token is reported with no matches
		push_text("ab cd\n");
		push_word(MODE_TEXT, 8'h00);
		push_word(MODE_TEXT, 8'h0D);
		push_word(MODE_TEXT, 8'hFF);
		push_text("  \n\nq");
		push_word(MODE_END, 8'hFF);
		push_word(MODE_END, 8'h00);
		drain_reports();

		// over-long length clamps to eight characters
		load_pattern(64'hFFFF_FFFF_FFFF_FFFF, 15, 8);
		repeat (9) push_word(MODE_TEXT, 8'hFF);
		push_word(MODE_TEXT, EOL_CHAR);
		drain_reports();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					send_idle_on = 1'b1;
					recv_idle_on = 1'b1;
					load_pattern({$urandom, $urandom}, 8, 0);
				end
				1: begin
					send_idle_on = 1'b0;
					recv_idle_on = 1'b0;
					plen_pick = $urandom_range(1, 7);
					load_pattern({$urandom, $urandom}, plen_pick, $urandom_range(1, plen_pick));
				end
				2: begin
					send_idle_on = 1'b1;
					recv_idle_on = 1'b0;
					load_pattern({$urandom, $urandom}, 8, 8);
				end
				3: begin
					send_idle_on = 1'b0;
					recv_idle_on = 1'b1;
					load_pattern({$urandom, $urandom}, 12, 4);
				end
				4: begin
					send_idle_on = 1'b1;
					recv_idle_on = 1'b1;
					load_pattern(64'd0, 0, 0);
				end
				default: begin
					send_idle_on = 1'b1;
					recv_idle_on = 1'b1;
					load_pattern({$urandom, $urandom}, 8, $urandom_range(9, 15));
				end
			endcase
			if (ph == 3) begin
				push_random_text(40);
				drain_reports();
				push_random_text(30);
			end else begin
				push_random_text(70);
			end
			drain_reports();
		end

		// end of text in the middle of a line, at full rate
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		push_text("z ");
		push_word(MODE_END, 8'h5A);
		push_text("c ");
		drain_reports();

		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
